// ===== src/tqpr_pkg.sv =====
// Shared types and constants for the two-queue page replacement block.
package tqpr_pkg;

  localparam int PAGE_W   = 16;  // width of the page fields on the ports
  localparam int FRAMES_W = 5;   // width of the frames register

  typedef enum logic [1:0] {
    OUT_MAIN_HIT  = 2'd0,
    OUT_GHOST_HIT = 2'd1,
    OUT_ENTRY_HIT = 2'd2,
    OUT_FAULT     = 2'd3
  } outcome_t;

endpackage

// ===== src/tqpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tqpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tqpr_fifo.sv =====
// Shift-register FIFO with removal at any index plus append, index 0 oldest.
module tqpr_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             flush,
  input  logic             rm_en,
  input  logic [IW-1:0]    rm_idx,
  input  logic             push_en,
  input  logic [WIDTH-1:0] push_data,
  input  logic [IW-1:0]    rd_idx,
  output logic [WIDTH-1:0] rd_data,
  output logic [WIDTH-1:0] head,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] q      [DEPTH];
  logic [WIDTH-1:0] q_next [DEPTH];
  logic [CW-1:0]    base;
  logic [CW-1:0]    count_next;

  always_comb begin
    base = count - CW'(rm_en);
    for (int j = 0; j < DEPTH; j++) begin
      // entries at and above the removed one slide down by one
      if (rm_en && (j >= int'(rm_idx)) && (j + 1 < DEPTH)) begin
        q_next[j] = q[(j + 1 < DEPTH) ? j + 1 : j];
      end else begin
        q_next[j] = q[j];
      end
      if (push_en && (CW'(j) == base)) begin
        q_next[j] = push_data;
      end
    end
    count_next = base + CW'(push_en);
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign rd_data = q[rd_idx];
  assign head    = q[0];

endmodule

// ===== src/two_queue_page_replacement.sv =====
// Top level: simplified 2Q page replacement with a scanning sequencer.
//
//  channel   signals                              direction
//  ------    -----------------------------------  ---------
//  in        in_valid/in_stall, page              into block
//  out       out_valid/out_stall, outcome, ...    out of block
//  config    frames_we, frames_wdata              into block
//
// One reference at a time. A single page comparator is shared by three scans:
// the main store (through the page RAM's registered read), the ghost FIFO and
// the entry FIFO (each up to its fill). A decision state after the main scan
// and a result state complete a transaction; the block then returns to idle
// before the next transaction is accepted.
// rst is synchronous: frames returns to 16 (capped at MAX_FRAMES), all stores
// empty. No clearing pass: valid bits and fill counts reset at once.
// A result waits in the output register while out_stall is high; a new
// transaction is accepted meanwhile, and the block holds its finished result
// in the result cycle until the output register frees up.
module two_queue_page_replacement #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tqpr_pkg::PAGE_W-1:0]      page,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       outcome,
  output logic                             main_evict_valid,
  output logic [tqpr_pkg::PAGE_W-1:0]      main_evicted_page,
  output logic                             ghost_drop_valid,
  output logic [tqpr_pkg::PAGE_W-1:0]      ghost_dropped_page,
  input  logic                             frames_we,
  input  logic [tqpr_pkg::FRAMES_W-1:0]    frames_wdata
);

  localparam int HALF = MAX_FRAMES / 2;
  localparam int MIW  = $clog2(MAX_FRAMES);          // main slot index / rank
  localparam int MCW  = $clog2(MAX_FRAMES + 1);      // main scan and count
  localparam int FIW  = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int FCW  = $clog2(HALF + 1);
  localparam logic [tqpr_pkg::FRAMES_W-1:0] FRAMES_RST =
    tqpr_pkg::FRAMES_W'((MAX_FRAMES < 16) ? MAX_FRAMES : 16);

  typedef enum logic [2:0] {
    S_IDLE, S_MSCAN, S_MDEC, S_GSCAN, S_ESCAN, S_DONE
  } state_t;

  state_t state;

  logic [tqpr_pkg::FRAMES_W-1:0] frames;
  logic [tqpr_pkg::FRAMES_W-1:0] frames_sat;
  logic [tqpr_pkg::FRAMES_W-1:0] half;

  logic [PAGE_BITS-1:0] p_reg;

  // main store bookkeeping
  logic           main_valid [MAX_FRAMES];
  logic [MIW-1:0] main_rank  [MAX_FRAMES];
  logic [MCW-1:0] main_cnt;
  logic           evict;

  // scan state
  logic [MCW-1:0]       mscan;
  logic [MIW-1:0]       mslot;
  logic                 hit_f;
  logic [MIW-1:0]       hit_slot;
  logic                 slot_f;
  logic [MIW-1:0]       ins_slot;
  logic [MIW-1:0]       lru_slot;
  logic [PAGE_BITS-1:0] lru_page;
  logic [FCW-1:0]       fscan;

  // result being built
  logic [1:0]           res_outcome;
  logic                 res_ev_valid;
  logic [PAGE_BITS-1:0] res_ev_page;
  logic                 res_dr_valid;
  logic [PAGE_BITS-1:0] res_dr_page;

  // shared comparator
  logic [PAGE_BITS-1:0] cmp_a;
  logic                 page_eq;

  logic                 ram_we;
  logic [PAGE_BITS-1:0] ram_rdata;

  logic                 e_rm, e_push, g_rm, g_push;
  logic [FIW-1:0]       g_rm_idx;
  logic [PAGE_BITS-1:0] e_rd, e_head, g_rd, g_head;
  logic [FCW-1:0]       e_cnt, g_cnt;
  logic                 e_full, g_full;
  logic                 scan_v;
  logic [MIW-1:0]       scan_rank;

  assign mslot     = mscan[MIW-1:0] - MIW'(1);
  assign scan_v    = main_valid[mslot];
  assign scan_rank = main_rank[mslot];
  assign evict     = 32'(main_cnt) >= 32'(frames);
  assign half      = frames >> 1;
  assign e_full    = 32'(e_cnt) >= 32'(half);
  assign g_full    = 32'(g_cnt) >= 32'(half);

  always_comb begin
    if (frames_wdata < tqpr_pkg::FRAMES_W'(2)) begin
      frames_sat = tqpr_pkg::FRAMES_W'(2);
    end else if (32'(frames_wdata) > MAX_FRAMES) begin
      frames_sat = tqpr_pkg::FRAMES_W'(MAX_FRAMES);
    end else begin
      frames_sat = frames_wdata;
    end
  end

  always_comb begin
    case (state)
      S_GSCAN: cmp_a = g_rd;
      S_ESCAN: cmp_a = e_rd;
      default: cmp_a = ram_rdata;
    endcase
  end
  assign page_eq = (cmp_a == p_reg);

  // FIFO control: ghost hit removes from the ghost FIFO; a fault pushes the page
  // into Ain, spilling its oldest page into Aout when Ain is full, which may drop its own.
  logic ghost_hit, fault;
  assign ghost_hit = (state == S_GSCAN) && (fscan != g_cnt) && page_eq;
  assign fault     = (state == S_ESCAN) && (fscan == e_cnt);
  assign e_rm      = fault && e_full;
  assign e_push    = fault;
  assign g_push    = e_rm;
  assign g_rm      = ghost_hit || (e_rm && g_full && (g_cnt != '0));
  assign g_rm_idx  = ghost_hit ? fscan[FIW-1:0] : '0;
  assign ram_we    = ghost_hit;

  tqpr_ram #(.WIDTH(PAGE_BITS), .DEPTH(MAX_FRAMES)) u_main_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ins_slot),
    .wdata (p_reg),
    .raddr (mscan[MIW-1:0]),
    .rdata (ram_rdata)
  );

  tqpr_fifo #(.WIDTH(PAGE_BITS), .DEPTH(HALF)) u_entry_fifo (
    .clk       (clk),
    .rst       (rst),
    .flush     (frames_we),
    .rm_en     (e_rm),
    .rm_idx    ('0),
    .push_en   (e_push),
    .push_data (p_reg),
    .rd_idx    (fscan[FIW-1:0]),
    .rd_data   (e_rd),
    .head      (e_head),
    .count     (e_cnt)
  );

  tqpr_fifo #(.WIDTH(PAGE_BITS), .DEPTH(HALF)) u_ghost_fifo (
    .clk       (clk),
    .rst       (rst),
    .flush     (frames_we),
    .rm_en     (g_rm),
    .rm_idx    (g_rm_idx),
    .push_en   (g_push),
    .push_data (e_head),
    .rd_idx    (fscan[FIW-1:0]),
    .rd_data   (g_rd),
    .head      (g_head),
    .count     (g_cnt)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      frames    <= FRAMES_RST;
      main_cnt  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        main_valid[i] <= 1'b0;
        main_rank[i]  <= '0;
      end
    end else begin
      // the result cycle reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (frames_we) begin
        frames   <= frames_sat;
        main_cnt <= '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          main_valid[i] <= 1'b0;
          main_rank[i]  <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            p_reg        <= PAGE_BITS'(page);
            mscan        <= '0;
            hit_f        <= 1'b0;
            slot_f       <= 1'b0;
            res_ev_valid <= 1'b0;
            res_ev_page  <= '0;
            res_dr_valid <= 1'b0;
            res_dr_page  <= '0;
            state        <= S_MSCAN;
          end
        end
        S_MSCAN: begin
          // read data now holds the entry one behind the read address
          if (mscan != '0) begin
            if (scan_v && page_eq && !hit_f) begin
              hit_f    <= 1'b1;
              hit_slot <= mslot;
            end
            if (scan_v && (scan_rank == MIW'(main_cnt - MCW'(1)))) begin
              lru_slot <= mslot;
              lru_page <= ram_rdata;
            end
            if (!slot_f && (!scan_v ||
                (evict && (scan_rank == MIW'(main_cnt - MCW'(1)))))) begin
              slot_f   <= 1'b1;
              ins_slot <= mslot;
            end
          end
          if (mscan == MCW'(MAX_FRAMES)) begin
            state <= S_MDEC;
          end else begin
            mscan <= mscan + MCW'(1);
          end
        end
        S_MDEC: begin
          if (hit_f) begin
            // move to most recent: younger entries age by one
            for (int i = 0; i < MAX_FRAMES; i++) begin
              if (main_valid[i] && (main_rank[i] < main_rank[hit_slot])) begin
                main_rank[i] <= main_rank[i] + MIW'(1);
              end
            end
            main_rank[hit_slot] <= '0;
            res_outcome <= tqpr_pkg::OUT_MAIN_HIT;
            state       <= S_DONE;
          end else begin
            fscan <= '0;
            state <= S_GSCAN;
          end
        end
        S_GSCAN: begin
          if (fscan == g_cnt) begin
            fscan <= '0;
            state <= S_ESCAN;
          end else if (page_eq) begin
            // promote into main store, evicting the LRU page when full
            for (int i = 0; i < MAX_FRAMES; i++) begin
              if (main_valid[i] && !(evict && (MIW'(i) == lru_slot))) begin
                main_rank[i] <= main_rank[i] + MIW'(1);
              end
            end
            if (evict) begin
              // the evicted slot is often the one refilled below
              if (ins_slot != lru_slot) begin
                main_valid[lru_slot] <= 1'b0;
              end
              res_ev_valid         <= 1'b1;
              res_ev_page          <= lru_page;
            end else begin
              main_cnt <= main_cnt + MCW'(1);
            end
            main_valid[ins_slot] <= 1'b1;
            main_rank[ins_slot]  <= '0;
            res_outcome          <= tqpr_pkg::OUT_GHOST_HIT;
            state                <= S_DONE;
          end else begin
            fscan <= fscan + FCW'(1);
          end
        end
        S_ESCAN: begin
          if (fault) begin
            if (g_rm) begin
              res_dr_valid <= 1'b1;
              res_dr_page  <= g_head;
            end
            res_outcome <= tqpr_pkg::OUT_FAULT;
            state       <= S_DONE;
          end else if (page_eq) begin
            res_outcome <= tqpr_pkg::OUT_ENTRY_HIT;
            state       <= S_DONE;
          end else begin
            fscan <= fscan + FCW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            outcome            <= res_outcome;
            main_evict_valid   <= res_ev_valid;
            main_evicted_page  <= tqpr_pkg::PAGE_W'(res_ev_page);
            ghost_drop_valid   <= res_dr_valid;
            ghost_dropped_page <= tqpr_pkg::PAGE_W'(res_dr_page);
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [MAX_FRAMES-1:0] valid_vec;
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      valid_vec[i] = main_valid[i];
    end
  end

  a_cnt_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(main_cnt) == $countones(valid_vec))
    else $error("main store count disagrees with valid bits");

  a_cnt_in_capacity: assert property (@(posedge clk) disable iff (rst)
    32'(main_cnt) <= 32'(frames))
    else $error("main store over capacity");

  a_fifo_in_capacity: assert property (@(posedge clk) disable iff (rst)
    (32'(e_cnt) <= 32'(half)) && (32'(g_cnt) <= 32'(half)))
    else $error("FIFO over capacity");

  a_evict_only_on_promote: assert property (@(posedge clk) disable iff (rst)
    (out_valid && main_evict_valid) |-> (outcome == tqpr_pkg::OUT_GHOST_HIT))
    else $error("eviction reported without a ghost promotion");

  a_drop_only_on_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ghost_drop_valid) |-> (outcome == tqpr_pkg::OUT_FAULT))
    else $error("ghost drop reported without a fault");

endmodule
